// File: design/salloc_pkg.sv
// Shared types and constants for the slot allocator with reuse delay.
// Used by salloc_engine and slot_allocator_with_reuse_delay; no dependencies.
package salloc_pkg;

	// Table geometry
	localparam int SLOTS   = 1024;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);

	// Field widths
	localparam int TIME_W  = 31;
	localparam int MS16_W  = 16;
	localparam int SLOT_W  = 10;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 31;

	// Opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes
	localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_FREE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_TIME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REUSE_DELAY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SLOT  = 2'd3;

	// Configuration reset values
	localparam logic [MS16_W-1:0] GRACE_RESET       = 16'd2000;
	localparam logic [MS16_W-1:0] REUSE_DELAY_RESET = 16'd1000;

	typedef struct packed {
		logic              opcode;
		logic [TIME_W-1:0] now_ms;
		logic [SLOT_W-1:0] slot_index;
		logic              no_relax;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] opened_count;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0] start_time_ms;
		logic [MS16_W-1:0] grace_ms;
		logic [MS16_W-1:0] reuse_delay_ms;
		logic [SLOT_W-1:0] first_slot;
	} cfg_t;

	// One table entry: in-use flag, quarantine-enable flag, free stamp
	typedef struct packed {
		logic              in_use;
		logic              held;
		logic [TIME_W-1:0] ftime;
	} entry_t;

endpackage

// File: design/salloc_engine.sv
// Slot table memory and the allocate/free sequencer with scan and rescan.
// Depends on salloc_pkg for types and constants.
module salloc_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  salloc_pkg::cfg_t  cfg,
	input  logic              req_valid,
	output logic              req_stall,
	input  salloc_pkg::req_t  req,
	output logic              res_valid,
	input  logic              res_ready,
	output salloc_pkg::res_t  res
);
	import salloc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_DONE
	} state_t;

	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	state_t            state_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  opened_q;
	logic              force_q;
	logic              op_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W:0]   limit_q;
	logic [IDX_W-1:0]  slot_q;
	logic [STAT_W-1:0] status_q;
	entry_t            wdata_q;
	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	entry_t            rd_data_s1;

	entry_t            mem [SLOTS];

	logic              issue;
	logic              hit;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic [CNT_W-1:0]  first_ext;
	logic [CNT_W-1:0]  next_slot;
	logic              can_open;

	// Quarantine test: held, stamped after start plus grace, and younger than the delay
	function automatic logic quarantined(entry_t e, logic [TIME_W-1:0] now,
			logic [TIME_W:0] limit, logic [MS16_W-1:0] delay);
		logic [TIME_W:0] age;
		age = {1'b0, now} - {1'b0, e.ftime};
		return e.held && ({1'b0, e.ftime} > limit) &&
			(age[TIME_W] || (age[TIME_W-1:0] < TIME_W'(delay)));
	endfunction

	// Scan control and slot choice
	always_comb begin
		issue     = (state_q == ST_SCAN) && (ptr_q < opened_q);
		hit       = rd_v_s1 && !rd_data_s1.in_use &&
			(force_q || !quarantined(rd_data_s1, now_q, limit_q, cfg.reuse_delay_ms));
		first_ext = CNT_W'(cfg.first_slot);
		next_slot = (opened_q > first_ext) ? opened_q : first_ext;
		can_open  = (next_slot < SLOTS_C) && (opened_q < SLOTS_C);
	end

	// Memory write port: clearing sweep or final write-back
	always_comb begin
		wr_en   = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
		wr_addr = (state_q == ST_CLEAR) ? ptr_q[IDX_W-1:0] : slot_q;
		wr_data = (state_q == ST_CLEAR) ? entry_t'('0) : wdata_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Memory read port: one slot per cycle during a scan
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[ptr_q[IDX_W-1:0]];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			ptr_q      <= '0;
			opened_q   <= '0;
			force_q    <= 1'b0;
			rd_v_s1    <= 1'b0;
			rd_addr_s1 <= '0;
			op_q       <= OP_ALLOC;
			now_q      <= '0;
			limit_q    <= '0;
			slot_q     <= '0;
			status_q   <= STATUS_OK;
			wdata_q    <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == SLOTS_C - 1'b1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					rd_v_s1 <= 1'b0;
					if (req_valid) begin
						op_q    <= req.opcode;
						now_q   <= req.now_ms;
						limit_q <= {1'b0, cfg.start_time_ms} + (TIME_W + 1)'(cfg.grace_ms);
						if (req.opcode == OP_FREE) begin
							slot_q <= IDX_W'(req.slot_index);
							if (CNT_W'(req.slot_index) >= opened_q) begin
								status_q <= STATUS_BAD_FREE;
								state_q  <= ST_DONE;
							end else begin
								wdata_q  <= '{in_use: 1'b0, held: !req.no_relax,
									ftime: (req.no_relax ? '0 : req.now_ms)};
								status_q <= STATUS_OK;
								state_q  <= ST_WRITE;
							end
						end else begin
							ptr_q   <= first_ext;
							force_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_v_s1    <= issue && !hit;
					rd_addr_s1 <= ptr_q[IDX_W-1:0];
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit) begin
						// take the first usable slot
						slot_q   <= rd_addr_s1;
						wdata_q  <= '{in_use: 1'b1, held: rd_data_s1.held,
							ftime: rd_data_s1.ftime};
						status_q <= STATUS_OK;
						state_q  <= ST_WRITE;
					end else if (!issue && !rd_v_s1) begin
						if (!force_q && can_open) begin
							// open a fresh slot
							slot_q   <= next_slot[IDX_W-1:0];
							opened_q <= next_slot + 1'b1;
							wdata_q  <= '{in_use: 1'b1, held: 1'b0, ftime: '0};
							status_q <= STATUS_OK;
							state_q  <= ST_WRITE;
						end else if (!force_q) begin
							// at capacity: rescan ignoring the delay
							force_q <= 1'b1;
							ptr_q   <= first_ext;
						end else begin
							slot_q   <= '0;
							status_q <= STATUS_FULL;
							state_q  <= ST_DONE;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall        = (state_q != ST_IDLE);
	assign res_valid        = (state_q == ST_DONE);
	assign res.slot         = SLOT_W'(slot_q);
	assign res.status       = status_q;
	assign res.opened_count = COUNT_W'(opened_q);

`ifndef SYNTHESIS
	a_opened_bound: assert property (@(posedge clk) disable iff (!arst_n)
		opened_q <= SLOTS_C)
		else $error("opened count exceeds table size");

	a_opened_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		opened_q >= $past(opened_q))
		else $error("opened count decreased");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && issue))
		else $error("table read and write in the same cycle");

	a_alloc_within_opened: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && op_q == OP_ALLOC && status_q == STATUS_OK)
		|-> (CNT_W'(slot_q) < opened_q))
		else $error("allocated slot not below opened count");
`endif

endmodule

// File: design/slot_allocator_with_reuse_delay.sv
// Top level: configuration registers, allocator engine and result register.
// Depends on salloc_pkg and salloc_engine.
// Free: the engine writes the slot entry, then offers the result to the output register;
// a rejected free offers its result without a write. Allocate: the engine scans the slot
// table from first_slot, one slot per cycle on its read port, and rescans ignoring the delay when full.
// One request in flight at a time; a finished result waits in the output register.
// After reset the slot table is cleared entry by entry before the first
// request transfer; configuration writes are taken throughout.
module slot_allocator_with_reuse_delay (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  salloc_pkg::req_t                          in_data,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output salloc_pkg::res_t                          out_data,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [salloc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [salloc_pkg::CFG_DAT_W-1:0]          cfg_data
);
	import salloc_pkg::*;

	cfg_t cfg_q;
	logic res_valid;
	logic res_ready;
	res_t res;
	logic out_valid_q;
	res_t out_q;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time_ms  <= '0;
			cfg_q.grace_ms       <= GRACE_RESET;
			cfg_q.reuse_delay_ms <= REUSE_DELAY_RESET;
			cfg_q.first_slot     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_START_TIME:  cfg_q.start_time_ms  <= TIME_W'(cfg_data);
				REG_GRACE:       cfg_q.grace_ms       <= cfg_data[MS16_W-1:0];
				REG_REUSE_DELAY: cfg_q.reuse_delay_ms <= cfg_data[MS16_W-1:0];
				REG_FIRST_SLOT:  cfg_q.first_slot     <= cfg_data[SLOT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	salloc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (in_valid),
		.req_stall (in_stall),
		.req       (in_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: load when empty or draining, drop when taken
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> out_valid_q)
		else $error("stalled result dropped");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");
`endif

endmodule

// File: bench/salloc_checker.sv
`timescale 1ns / 1ps
// Checker for the slot allocator: watches the config, request and result channels.
// Predicts each result from a shadow slot table and compares; depends on salloc_pkg.
module salloc_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  salloc_pkg::req_t                 in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  salloc_pkg::res_t                 out_data,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [salloc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [salloc_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                               fail_count,
	output int                               pending_count
);
	import salloc_pkg::*;

	// Shadow configuration
	logic [TIME_W-1:0] start_time_ms;
	logic [MS16_W-1:0] grace_ms;
	logic [MS16_W-1:0] reuse_delay_ms;
	logic [SLOT_W-1:0] first_slot;

	// Shadow slot table
	bit                busy [SLOTS];
	bit                held [SLOTS];
	logic [TIME_W-1:0] freed_at [SLOTS];
	int                opened;

	res_t expected_replies [$];
	res_t want;
	int   failures;

	// Count a failure, print only the first few
	function automatic void flag_error(string msg);
		failures++;
		if (failures <= 10) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// A held slot freed after start plus grace is held back while it is younger than the reuse delay
	function automatic bit in_quarantine(int s, logic [TIME_W-1:0] now);
		longint age;
		if (!held[s]) begin
			return 1'b0;
		end
		if (longint'(freed_at[s]) <= longint'(start_time_ms) + longint'(grace_ms)) begin
			return 1'b0;
		end
		age = longint'(now) - longint'(freed_at[s]);
		return age < longint'(reuse_delay_ms);
	endfunction

	// Lowest free opened slot at or above first_slot, or -1
	function automatic int find_slot(logic [TIME_W-1:0] now, bit ignore_delay);
		for (int s = int'(first_slot); s < opened && s < SLOTS; s++) begin
			if (busy[s]) begin
				continue;
			end
			if (!ignore_delay && in_quarantine(s, now)) begin
				continue;
			end
			return s;
		end
		return -1;
	endfunction

	// Apply one request to the shadow table and return the reply it must produce
	function automatic res_t predict_reply(req_t r);
		res_t res;
		int   found;
		int   next;
		res.slot   = '0;
		res.status = STATUS_OK;
		if (r.opcode == OP_ALLOC) begin
			found = find_slot(r.now_ms, 1'b0);
			if (found < 0) begin
				next = (opened > int'(first_slot)) ? opened : int'(first_slot);
				if (next < SLOTS && opened < SLOTS) begin
					found  = next;
					opened = next + 1;
				end else begin
					found = find_slot(r.now_ms, 1'b1);
				end
			end
			if (found < 0) begin
				res.status = STATUS_FULL;
			end else begin
				res.slot     = SLOT_W'(found);
				busy[found] = 1'b1;
			end
		end else begin
			res.slot = r.slot_index;
			if (int'(r.slot_index) >= opened) begin
				res.status = STATUS_BAD_FREE;
			end else begin
				busy[r.slot_index] = 1'b0;
				if (r.no_relax) begin
					held[r.slot_index]     = 1'b0;
					freed_at[r.slot_index] = '0;
				end else begin
					held[r.slot_index]     = 1'b1;
					freed_at[r.slot_index] = r.now_ms;
				end
			end
		end
		res.opened_count = COUNT_W'(opened);
		return res;
	endfunction

	// Track config writes, compare result transfers, predict request transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_ms  = '0;
			grace_ms       = GRACE_RESET;
			reuse_delay_ms = REUSE_DELAY_RESET;
			first_slot     = '0;
			for (int s = 0; s < SLOTS; s++) begin
				busy[s]     = 1'b0;
				held[s]     = 1'b0;
				freed_at[s] = '0;
			end
			opened = 0;
			expected_replies.delete();
			failures = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_TIME:  start_time_ms  = cfg_data[TIME_W-1:0];
					REG_GRACE:       grace_ms       = cfg_data[MS16_W-1:0];
					REG_REUSE_DELAY: reuse_delay_ms = cfg_data[MS16_W-1:0];
					REG_FIRST_SLOT:  first_slot     = cfg_data[SLOT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					flag_error($sformatf("unexpected result: slot %0d status %0d opened %0d",
						out_data.slot, out_data.status, out_data.opened_count));
				end else begin
					want = expected_replies.pop_front();
					if (out_data.slot !== want.slot || out_data.status !== want.status ||
						out_data.opened_count !== want.opened_count) begin
						flag_error($sformatf(
							"mismatch: expected slot %0d status %0d opened %0d, got slot %0d status %0d opened %0d",
							want.slot, want.status, want.opened_count,
							out_data.slot, out_data.status, out_data.opened_count));
					end
				end
			end
			if (in_valid && !in_stall) begin
				expected_replies.push_back(predict_reply(in_data));
			end
			pending_count <= expected_replies.size();
			fail_count    <= failures;
		end
	end

endmodule

// File: bench/tb_slot_allocator_with_reuse_delay.sv
`timescale 1ns / 1ps
// Testbench top for slot_allocator_with_reuse_delay: clock, reset, stimulus, verdict.
// Depends on salloc_pkg, the block itself and salloc_checker.
module tb_slot_allocator_with_reuse_delay;
	import salloc_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	req_t                 in_data;
	logic                 out_valid;
	logic                 out_stall;
	res_t                 out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int unsigned base_ms;
	int unsigned rnd;
	int          drain_cycles;

	slot_allocator_with_reuse_delay u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	salloc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Hard limit on run length
	initial begin
		#100_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Drive one request, with a random idle gap ahead of it; return at its transfer
	task automatic send_request(input req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic request(input logic op, input int unsigned now, input int unsigned idx,
		input logic nr);
		req_t r;
		r.opcode     = op;
		r.now_ms     = TIME_W'(now);
		r.slot_index = SLOT_W'(idx);
		r.no_relax   = nr;
		send_request(r);
	endtask

	// Random request; frees mostly aim at the slot window [lo, hi]
	task automatic random_item(input int unsigned lo, input int unsigned hi);
		req_t        r;
		int unsigned pick;
		r.opcode = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
		base_ms  = (base_ms + $urandom_range(0, 400)) & 32'h7FFF_FFFF;
		pick     = $urandom_range(0, 99);
		if (pick < 8) begin
			r.now_ms = TIME_W'($urandom);
		end else if (pick < 16) begin
			r.now_ms = TIME_W'(base_ms - $urandom_range(0, 1500));
		end else begin
			r.now_ms = TIME_W'(base_ms);
		end
		r.slot_index = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(lo, hi))
			: SLOT_W'($urandom);
		r.no_relax   = ($urandom_range(0, 99) < 25);
		send_request(r);
	endtask

	// Hold the request side until every expected result has been taken
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Write all four registers while the block is idle
	task automatic configure(input logic [CFG_DAT_W-1:0] start, input logic [CFG_DAT_W-1:0] grace,
		input logic [CFG_DAT_W-1:0] delay, input logic [CFG_DAT_W-1:0] first);
		wait_idle();
		write_reg(REG_START_TIME, start);
		write_reg(REG_GRACE, grace);
		write_reg(REG_REUSE_DELAY, delay);
		write_reg(REG_FIRST_SLOT, first);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		base_ms        = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset configuration
		request(OP_FREE, 0, 5, 1'b0);               // free before anything is opened
		request(OP_ALLOC, 100, 0, 1'b0);
		request(OP_ALLOC, 100, 0, 1'b0);
		request(OP_ALLOC, 200, 0, 1'b0);
		request(OP_ALLOC, 300, 0, 1'b0);
		request(OP_FREE, 3000, 1, 1'b0);
		request(OP_ALLOC, 3500, 0, 1'b0);           // slot 1 too young: open a new one
		request(OP_ALLOC, 4000, 0, 1'b0);           // slot 1 exactly old enough
		request(OP_FREE, 5000, 2, 1'b1);            // no_relax: reusable at once
		request(OP_ALLOC, 5000, 0, 1'b0);
		request(OP_FREE, 1500, 3, 1'b0);            // freed inside the grace window
		request(OP_ALLOC, 1600, 0, 1'b0);
		request(OP_FREE, 10000, 0, 1'b0);
		request(OP_ALLOC, 9000, 0, 1'b0);           // time ran backwards: still held
		request(OP_FREE, 10000, 0, 1'b0);           // free an already free slot
		request(OP_FREE, 0, 1023, 1'b0);
		request(OP_FREE, 0, 6, 1'b0);               // index equal to the opened count
		request(OP_FREE, 32'h7FFF_FFFF, 4, 1'b0);
		request(OP_ALLOC, 0, 1023, 1'b1);
		request(OP_ALLOC, 32'h7FFF_FFFF, 0, 1'b0);

		// Long reuse delay, no grace
		base_ms = 20000;
		configure(0, 0, 16'hFFFF, 0);
		set_idling(0, 0);
		repeat (60) random_item(0, 47);

		// Nothing held back, first slot beyond the opened count, sender idles
		base_ms = $urandom_range(0, 1 << 30);
		configure(31'h7FFF_FFFF, 16'hFFFF, 0, 100);
		set_idling(54, 0);
		repeat (55) random_item(90, 135);

		// Random settings, junk in the unused upper data bits, receiver stalls
		rnd     = $urandom;
		base_ms = $urandom_range(0, 1 << 30);
		configure(CFG_DAT_W'(base_ms), CFG_DAT_W'($urandom), CFG_DAT_W'($urandom_range(0, 3000)),
			CFG_DAT_W'($urandom_range(0, 15)));
		base_ms = base_ms + rnd[15:0] + $urandom_range(0, 4000);
		set_idling(0, 54);
		repeat (60) random_item(0, 140);

		// Near the reset values, both sides idle, one full drain midway
		base_ms = $urandom_range(0, 1 << 29);
		configure(CFG_DAT_W'(base_ms), 2000, 1000, 3);
		set_idling(25, 25);
		for (int i = 0; i < 60; i++) begin
			if (i == 30) begin
				wait_idle();
			end
			random_item(0, 140);
		end

		// Top slot: fill the table, then forced reuse and full
		base_ms = 50000;
		configure(0, 0, 16'hFFFF, 1023);
		set_idling(0, 0);
		request(OP_ALLOC, 50000, 0, 1'b0);
		request(OP_ALLOC, 50000, 0, 1'b0);
		request(OP_FREE, 50000, 1023, 1'b0);
		request(OP_ALLOC, 50000, 0, 1'b0);          // only held slot left: take it anyway
		request(OP_FREE, 50000, 1023, 1'b1);
		request(OP_ALLOC, 50000, 0, 1'b0);
		request(OP_ALLOC, 50000, 0, 1'b0);

		// Small window at the top of a full table, cycling idle modes
		base_ms = $urandom_range(0, 1 << 29);
		configure(CFG_DAT_W'(base_ms), CFG_DAT_W'($urandom_range(0, 500)),
			CFG_DAT_W'($urandom_range(0, 3000)), 1000);
		for (int i = 0; i < 50; i++) begin
			case (i / 10)
				0: set_idling(0, 0);
				1: set_idling(54, 0);
				2: set_idling(0, 54);
				3: set_idling(25, 25);
				default: set_idling(0, 0);
			endcase
			if (i == 25) begin
				wait_idle();
			end
			random_item(995, 1023);
		end

		// Drain and settle
		in_valid <= 1'b0;
		drain_cycles = 0;
		while (pending_count != 0 && drain_cycles < 50000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: slot_allocator_with_reuse_delay.f
design/salloc_pkg.sv
design/salloc_engine.sv
design/slot_allocator_with_reuse_delay.sv
bench/salloc_checker.sv
bench/tb_slot_allocator_with_reuse_delay.sv
